[hdl/swcre_pkg.sv]
// ----------------------------------------------------------------------------
// Clock rate estimator package
// Shared widths, constants, register indexes and request types of the
// sliding-window clock rate estimator.
// ----------------------------------------------------------------------------
package swcre_pkg;

  // Smoothing window
  localparam int unsigned WinDepth = 16;
  localparam int unsigned WinPosW  = $clog2(WinDepth);

  // Field and datapath widths
  localparam int unsigned TickW    = 64;
  localparam int unsigned SecW     = 32;
  localparam int unsigned NsecW    = 30;
  localparam int unsigned NsW      = 34;
  localparam int unsigned NsSumW   = NsW + WinPosW;
  localparam int unsigned ProdW    = SecW + NsecW;
  localparam int unsigned TimeW    = ProdW + 1;
  localparam int unsigned RateW    = 32;
  localparam int unsigned GenW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 34;

  // Time base and rate scaling (ns to kHz needs a factor of one million)
  localparam logic [NsecW-1:0] NsPerSec   = 30'd1000000000;
  localparam int unsigned      ScaleW     = 20;
  localparam logic [ScaleW-1:0] RateScale = 20'd1000000;
  localparam int unsigned      ScaleIdxW  = $clog2(ScaleW);

  // Iteration count of the serial divider and width of the step counter it shares with the multiplier
  localparam int unsigned DivSteps = TickW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Register reset values
  localparam logic [NsW-1:0]   MaxGapReset   = 34'd10000000000;
  localparam logic [RateW-1:0] WarnLowReset  = 32'd400000;
  localparam logic [RateW-1:0] WarnHighReset = 32'd10000000;

  // Generation counter skips zero on wrap
  localparam logic [GenW-1:0] GenWrapPoint = 32'hFFFF_FFFE;
  localparam logic [GenW-1:0] GenRestart   = 32'd2;
  localparam logic [GenW-1:0] GenStep      = 32'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_GAP   = 2'd0,
    CFG_WARN_LOW  = 2'd1,
    CFG_WARN_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] counter_value;
    logic [SecW-1:0]  mono_seconds;
    logic [NsecW-1:0] mono_nanoseconds;
  } in_item_t;

  typedef struct packed {
    logic [RateW-1:0] rate_khz;
    logic             rate_valid;
    logic             sample_accepted;
    logic             range_warning;
    logic [GenW-1:0]  generation;
  } out_item_t;

endpackage

[hdl/sliding_window_clock_rate_estimator_top.sv]
// ----------------------------------------------------------------------------
// Sliding-window clock rate estimator
// Turns paired counter/time samples into a smoothed counter rate in kHz
// using a 16-deep window of tick and nanosecond deltas.
// ----------------------------------------------------------------------------
// Each request passes ST_MULT, ST_SUM, ST_DIFF and ST_UPDATE to ST_DONE; when
//   a rate is computed, 20-step shift-add scaling by one million (ST_PROD) and
//   a 64-step radix-2 restoring divider (ST_DIV) run first, then ST_RATE.
// One request is in work at a time. Reset: asynchronous, active low; clears
// state, window and registers except the datapath and output data registers.
module sliding_window_clock_rate_estimator_top import swcre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MULT   = 9'b000000010,
    ST_SUM    = 9'b000000100,
    ST_DIFF   = 9'b000001000,
    ST_UPDATE = 9'b000010000,
    ST_PROD   = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_RATE   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [NsW-1:0]   max_gap_q;
  logic [RateW-1:0] warn_low_q, warn_high_q;

  // Captured request and time datapath
  logic [TickW-1:0] cnt_in_q;
  logic [SecW-1:0]  sec_in_q;
  logic [NsecW-1:0] nsec_in_q;
  logic [ProdW-1:0] prod_q;
  logic [TimeW-1:0] now_t_q;
  logic [TimeW-1:0] diff_q;
  logic [TickW-1:0] ticks_q;
  logic             later_q;
  logic [TimeW:0]   diff_full;

  // Baseline and window state
  logic             base_valid_q;
  logic [TickW-1:0] last_cnt_q;
  logic [TimeW-1:0] last_t_q;
  logic [TickW-1:0] tick_win_q [WinDepth];
  logic [NsW-1:0]   ns_win_q   [WinDepth];
  logic [WinPosW-1:0] pos_q;
  logic [TickW-1:0] tick_sum_q, tick_sum_d;
  logic [NsSumW-1:0] ns_sum_q, ns_sum_d;
  logic [1:0]       acc_cnt_q;
  logic             warned_q;
  logic [RateW-1:0] rate_q;
  logic [GenW-1:0]  gen_q;
  logic             accepted_q;
  logic             gap_ok, accept_now;

  // Serial multiplier / divider
  logic [StepW-1:0]  step_q;
  logic [TickW-1:0]  work_q, work_d;
  logic [TickW-1:0]  mcand_q;
  logic [NsSumW-1:0] rem_q;
  logic [NsSumW:0]   div_shift;
  logic [NsSumW+1:0] div_trial;

  // Output register
  logic      out_valid_q;
  out_item_t out_data_q;
  logic      out_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign diff_full  = {1'b0, now_t_q} - {1'b0, last_t_q};
  assign gap_ok     = (diff_q[TimeW-1:NsW] == '0) && (diff_q[NsW-1:0] <= max_gap_q);
  assign accept_now = base_valid_q && later_q && gap_ok;

  assign tick_sum_d = tick_sum_q + ticks_q - tick_win_q[pos_q];
  assign ns_sum_d   = ns_sum_q + NsSumW'(diff_q[NsW-1:0]) - NsSumW'(ns_win_q[pos_q]);

  // One quotient bit per cycle; the dividend shifts out at the top of work_q
  // while quotient bits shift in at the bottom.
  assign div_shift = {rem_q, work_q[TickW-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, ns_sum_q};

  always_comb begin
    work_d = work_q;
    if (RateScale[step_q[ScaleIdxW-1:0]]) begin
      work_d = work_q + mcand_q;
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MULT;
      ST_MULT:   state_d = ST_SUM;
      ST_SUM:    state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = (accept_now && acc_cnt_q != 2'd0) ? ST_PROD : ST_DONE;
      ST_PROD:   if (step_q == StepW'(ScaleW - 1)) state_d = ST_DIV;
      ST_DIV:    if (step_q == StepW'(DivSteps - 1)) state_d = ST_RATE;
      ST_RATE:   state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q   <= MaxGapReset;
      warn_low_q  <= WarnLowReset;
      warn_high_q <= WarnHighReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_GAP:   max_gap_q   <= cfg_data_i;
        CFG_WARN_LOW:  warn_low_q  <= cfg_data_i[RateW-1:0];
        CFG_WARN_HIGH: warn_high_q <= cfg_data_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  // Request capture and time arithmetic
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cnt_in_q  <= in_data_i.counter_value;
      sec_in_q  <= in_data_i.mono_seconds;
      nsec_in_q <= in_data_i.mono_nanoseconds;
    end
    if (state_q == ST_MULT) begin
      prod_q <= ProdW'(sec_in_q) * ProdW'(NsPerSec);
    end
    if (state_q == ST_SUM) begin
      now_t_q <= {1'b0, prod_q} + TimeW'(nsec_in_q);
    end
    if (state_q == ST_DIFF) begin
      diff_q  <= diff_full[TimeW-1:0];
      later_q <= !diff_full[TimeW] && (diff_full[TimeW-1:0] != '0);
      ticks_q <= cnt_in_q - last_cnt_q;
    end
  end

  // Baseline, window and status state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_valid_q <= 1'b0;
      last_cnt_q   <= '0;
      last_t_q     <= '0;
      tick_win_q   <= '{default: '0};
      ns_win_q     <= '{default: '0};
      pos_q        <= '0;
      tick_sum_q   <= '0;
      ns_sum_q     <= '0;
      acc_cnt_q    <= 2'd0;
      warned_q     <= 1'b0;
      rate_q       <= '0;
      gen_q        <= '0;
      accepted_q   <= 1'b0;
    end else begin
      if (state_q == ST_UPDATE) begin
        base_valid_q <= 1'b1;
        last_cnt_q   <= cnt_in_q;
        last_t_q     <= now_t_q;
        accepted_q   <= accept_now;
        if (base_valid_q) begin
          gen_q <= (gen_q == GenWrapPoint) ? GenRestart : gen_q + GenStep;
        end
        if (accept_now) begin
          tick_sum_q        <= tick_sum_d;
          ns_sum_q          <= ns_sum_d;
          tick_win_q[pos_q] <= ticks_q;
          ns_win_q[pos_q]   <= diff_q[NsW-1:0];
          pos_q <= (pos_q == WinPosW'(WinDepth - 1)) ? '0 : pos_q + 1'b1;
          if (acc_cnt_q == 2'd0) begin
            acc_cnt_q <= 2'd1;
          end
        end
      end
      if (state_q == ST_RATE) begin
        rate_q    <= work_q[RateW-1:0];
        acc_cnt_q <= 2'd2;
        if (work_q[RateW-1:0] < warn_low_q || work_q[RateW-1:0] > warn_high_q) begin
          warned_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add scaling, then restoring division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == ST_UPDATE) begin
      step_q <= '0;
    end else if (state_q == ST_PROD) begin
      step_q <= (step_q == StepW'(ScaleW - 1)) ? '0 : step_q + 1'b1;
    end else if (state_q == ST_DIV) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_UPDATE: begin
        work_q  <= '0;
        mcand_q <= tick_sum_d;
        rem_q   <= '0;
      end
      ST_PROD: begin
        work_q  <= work_d;
        mcand_q <= {mcand_q[TickW-2:0], 1'b0};
      end
      ST_DIV: begin
        if (!div_trial[NsSumW+1]) begin
          rem_q <= div_trial[NsSumW-1:0];
        end else begin
          rem_q <= div_shift[NsSumW-1:0];
        end
        work_q <= {work_q[TickW-2:0], !div_trial[NsSumW+1]};
      end
      default: ;
    endcase
  end

  // Output register decouples the result from the next request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.rate_khz        <= rate_q;
      out_data_q.rate_valid      <= (acc_cnt_q == 2'd2);
      out_data_q.sample_accepted <= accepted_q;
      out_data_q.range_warning   <= warned_q;
      out_data_q.generation      <= gen_q;
    end
  end

  // A new request always starts the time computation.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_MULT)
    else $error("accepted request did not start processing");

  // The divider runs to completion before the rate is taken.
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |=> (state_q == ST_DIV || state_q == ST_RATE))
    else $error("divider left early");

  // A rate is only formed once an earlier delta sits in the window.
  a_rate_needs_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RATE |-> acc_cnt_q != 2'd0)
    else $error("rate computed without a prior accepted delta");

  // A valid rate implies at least one counted update, so generation is nonzero.
  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.rate_valid |-> out_data_q.generation != '0)
    else $error("valid rate reported with zero generation");

endmodule
